// File: rtl/ftrp_pkg.sv
// Shared types, event codes and constant byte tables for the framed reply parser.
// No dependencies.
package ftrp_pkg;

	localparam int unsigned MAX_PAYLOAD = 4096;
	localparam int unsigned NAME_BYTES  = 128;
	localparam int unsigned AVATAR_MAX  = 4096;
	localparam int unsigned TICKET_MAX  = 2048;
	localparam int unsigned HDR_LEN     = 11;
	localparam int unsigned EVQ_DEPTH   = 4;

	typedef enum logic [4:0] {
		EV_BAD_MAGIC      = 5'd0,
		EV_UNKNOWN_REPLY  = 5'd1,
		EV_CHAL_MISMATCH  = 5'd2,
		EV_TICKET_BIG     = 5'd3,
		EV_IDENTITY       = 5'd4,
		EV_TICKET_BYTE    = 5'd5,
		EV_PLAYER_BEGIN   = 5'd6,
		EV_NAME_BYTE      = 5'd7,
		EV_NAME_LONG      = 5'd8,
		EV_AVATAR_BYTE    = 5'd9,
		EV_AVATAR_BIG     = 5'd10,
		EV_RELATION       = 5'd11,
		EV_GAME           = 5'd12,
		EV_PERSONA        = 5'd13,
		EV_UNKNOWN_FIELD  = 5'd14,
		EV_PLAYER_DONE    = 5'd15,
		EV_PLAYER_ABANDON = 5'd16,
		EV_OVERFLOW       = 5'd17
	} ev_code_t;

	// field type codes
	localparam logic [7:0] FT_NAME     = 8'd1;
	localparam logic [7:0] FT_AVATAR   = 8'd2;
	localparam logic [7:0] FT_RSV3     = 8'd3;
	localparam logic [7:0] FT_RSV4     = 8'd4;
	localparam logic [7:0] FT_RELATION = 8'd5;
	localparam logic [7:0] FT_RSV6     = 8'd6;
	localparam logic [7:0] FT_GAME     = 8'd7;
	localparam logic [7:0] FT_RSV8     = 8'd8;
	localparam logic [7:0] FT_PERSONA  = 8'd9;

	typedef struct packed {
		logic [4:0]  event_res;
		logic [63:0] value;
		logic [7:0]  data_byte;
		logic [7:0]  field_kind;
		logic        last;
	} ev_t;

	// events produced by one input byte, at most two
	typedef struct packed {
		logic [1:0] n;
		ev_t        e0;
		ev_t        e1;
	} push_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = 8'h53;
			2'd1: r = 8'h42;
			2'd2: r = 8'h52;
			default: r = 8'h4B;
		endcase
		return r;
	endfunction

	// reply header tables; the two differ only at positions 3..6, 8 and 9
	function automatic logic [7:0] hdr_byte(input logic player, input logic [3:0] idx);
		logic [7:0] r;
		unique case (idx)
			4'd0: r = "s";
			4'd1: r = "b";
			4'd2: r = "_";
			4'd3: r = player ? "p" : "c";
			4'd4: r = player ? "l" : "o";
			4'd5: r = player ? "a" : "n";
			4'd6: r = player ? "y" : "n";
			4'd7: r = "e";
			4'd8: r = player ? "r" : "c";
			4'd9: r = player ? "x" : "t";
			default: r = 8'h0A;
		endcase
		return r;
	endfunction

	function automatic ev_t mk_ev(input ev_code_t c, input logic [63:0] v,
			input logic [7:0] d, input logic [7:0] k, input logic l);
		ev_t e;
		e.event_res  = c;
		e.value      = v;
		e.data_byte  = d;
		e.field_kind = k;
		e.last       = l;
		return e;
	endfunction

endpackage

// File: rtl/ftrp_in_if.sv
// Input channel: one received byte per beat, with restart flag.
// Depends on nothing.
interface ftrp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       restart;
	modport source (output valid, output rx_byte, output restart, input ready);
	modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

// File: rtl/ftrp_out_if.sv
// Output channel: one parser event per beat.
// Depends on nothing.
interface ftrp_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  event_res;
	logic [63:0] value;
	logic [7:0]  data_byte;
	logic [7:0]  field_kind;
	logic        last;
	modport source (output valid, output event_res, output value, output data_byte,
		output field_kind, output last, input ready);
	modport sink (input valid, input event_res, input value, input data_byte,
		input field_kind, input last, output ready);
endinterface

// File: rtl/framed_tlv_response_parser_core.sv
// Top level of the framed reply parser: byte-wide state machine plus event queue.
// Depends on ftrp_pkg, ftrp_in_if, ftrp_out_if, ftrp_step, ftrp_evq.
//
//   channel   dir  beat
//   in_ch     in   rx_byte[7:0], restart
//   out_ch    out  event_res[4:0], value[63:0], data_byte[7:0], field_kind[7:0], last
//   cfg       in   cfg_wr_en, cfg_wr_data[31:0] (expected challenge)
//
// One byte per cycle; each byte is parsed in the cycle it is taken and its 0..2 events
// land in a 4-entry queue. A byte is taken whenever the queue has two free slots, so
// the input keeps full rate unless the output drains slower than events are produced.
// Reset clears parse state, the challenge register and the queue.
module framed_tlv_response_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	ftrp_in_if.sink     in_ch,
	ftrp_out_if.source  out_ch
);
	import ftrp_pkg::*;

	push_t push;
	ev_t   head;
	logic  room2;
	logic  take;

	assign in_ch.ready = room2;
	assign take        = in_ch.valid && room2;

	ftrp_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.take        (take),
		.rx_byte     (in_ch.rx_byte),
		.restart     (in_ch.restart),
		.push        (push)
	);

	ftrp_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.head      (head)
	);

	assign out_ch.event_res  = head.event_res;
	assign out_ch.value      = head.value;
	assign out_ch.data_byte  = head.data_byte;
	assign out_ch.field_kind = head.field_kind;
	assign out_ch.last       = head.last;

	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!take |-> push.n == 2'd0) else $error("events pushed without an input beat");

	a_push_range: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd3) else $error("more than two events from one byte");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |=> out_ch.valid) else $error("queued event not presented");

endmodule

// File: rtl/ftrp_step.sv
// Parser state registers and the per-byte next-state / event logic.
// Depends on ftrp_pkg.
module ftrp_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               take,
	input  logic [7:0]         rx_byte,
	input  logic               restart,
	output ftrp_pkg::push_t    push
);
	import ftrp_pkg::*;

	typedef enum logic [4:0] {
		PH_HUNT = 5'd0, PH_LEN0 = 5'd1, PH_LEN1 = 5'd2, PH_HDR = 5'd3, PH_SKIP = 5'd4,
		PH_CHAL = 5'd5, PH_CID = 5'd6, PH_TSIZE = 5'd7, PH_TICKET = 5'd8, PH_PID = 5'd9,
		PH_PFLAGS = 5'd10, PH_FTYPE = 5'd11, PH_FLEN = 5'd12, PH_FDATA = 5'd13,
		PH_FBYTE = 5'd14, PH_FGAME = 5'd15, PH_FSKIP = 5'd16
	} phase_t;

	phase_t      phase_q, ph;
	logic [3:0]  mc_q, mc;
	logic [15:0] pl_q, pl;
	logic [31:0] fl_q, fl;
	logic [7:0]  ct_q, ct;
	logic [63:0] gs_q, gs;
	logic [1:0]  rk_q, rk;
	logic [31:0] chal_q;

	ev_t        e0, e1;
	logic [1:0] n;
	logic       done;
	logic [1:0] hidx;
	logic [3:0] idx;
	logic [31:0] len;

	function automatic void emit(inout ev_t a, inout ev_t b, inout logic [1:0] cnt,
			input ev_t e);
		if (cnt == 2'd0) begin
			a = e;
		end else begin
			b = e;
		end
		cnt = cnt + 2'd1;
	endfunction

	always_comb begin
		ph = phase_q; mc = mc_q; pl = pl_q; fl = fl_q;
		ct = ct_q; gs = gs_q; rk = rk_q;
		e0 = '0; e1 = '0; n = 2'd0; done = 1'b0;
		hidx = 2'd0; idx = 4'd0; len = 32'd0;
		if (restart) begin
			ph = PH_HUNT; mc = '0; pl = '0; fl = '0; ct = '0; gs = '0; rk = '0;
		end
		if (ph >= PH_HDR) begin
			if (pl == 16'd0) begin
				// frame ran out: this byte starts a fresh magic hunt
				ph = PH_HUNT; mc = '0; fl = '0; ct = '0; gs = '0; rk = '0;
				done = 1'b1;
				if (rx_byte == magic_byte(2'd0)) begin
					mc = 4'd1;
				end else begin
					emit(e0, e1, n, mk_ev(EV_BAD_MAGIC, '0, '0, '0, 1'b0));
				end
			end else begin
				pl = pl - 16'd1;
			end
		end
		if (!done) begin
			unique case (ph)
				PH_HUNT: begin
					hidx = mc[1:0];
					if (rx_byte == magic_byte(hidx)) begin
						mc = {2'b00, hidx} + 4'd1;
						if (mc == 4'd4) begin
							ph = PH_LEN0; mc = '0; gs = '0;
						end
					end else begin
						emit(e0, e1, n, mk_ev(EV_BAD_MAGIC, '0, '0, '0, 1'b0));
						mc = (rx_byte == magic_byte(2'd0)) ? 4'd1 : 4'd0;
					end
				end
				PH_LEN0: begin
					gs = gs | ({56'd0, rx_byte} << {mc[2:0], 3'b000});
					mc = mc + 4'd1;
					ph = PH_LEN1;
				end
				PH_LEN1: begin
					len = {16'd0, rx_byte, gs[7:0]};
					if (len > 32'(MAX_PAYLOAD)) begin
						emit(e0, e1, n, mk_ev(EV_OVERFLOW, {32'd0, len}, '0, '0, 1'b0));
						ph = PH_HUNT; mc = '0; pl = '0; fl = '0; ct = '0; gs = '0; rk = '0;
					end else if (len == 32'd0) begin
						emit(e0, e1, n, mk_ev(EV_UNKNOWN_REPLY, '0, '0, '0, 1'b0));
						ph = PH_HUNT; mc = '0; pl = '0; fl = '0; ct = '0; gs = '0; rk = '0;
					end else begin
						pl = len[15:0]; ph = PH_HDR; mc = '0; rk = 2'd3;
					end
				end
				PH_HDR: begin
					idx = (mc >= 4'(HDR_LEN)) ? 4'(HDR_LEN - 1) : mc;
					if (rx_byte != hdr_byte(1'b0, idx)) rk[0] = 1'b0;
					if (rx_byte != hdr_byte(1'b1, idx)) rk[1] = 1'b0;
					mc = idx + 4'd1;
					if (rk == 2'd0) begin
						emit(e0, e1, n, mk_ev(EV_UNKNOWN_REPLY, '0, '0, '0, 1'b0));
						ph = (pl == 16'd0) ? PH_HUNT : PH_SKIP;
					end else if (mc == 4'(HDR_LEN)) begin
						if (rk[0]) begin
							if (pl == 16'd0) begin
								emit(e0, e1, n, mk_ev(EV_OVERFLOW, '0, '0, '0, 1'b0));
								ph = PH_HUNT;
							end else begin
								ph = PH_CHAL; mc = '0; gs = '0;
							end
						end else if (pl < 16'd12) begin
							emit(e0, e1, n, mk_ev(EV_PLAYER_ABANDON, '0, '0, '0, 1'b0));
							ph = (pl == 16'd0) ? PH_HUNT : PH_SKIP;
						end else begin
							ph = PH_PID; mc = '0; gs = '0;
						end
					end else if (pl == 16'd0) begin
						emit(e0, e1, n, mk_ev(EV_UNKNOWN_REPLY, '0, '0, '0, 1'b0));
						ph = PH_HUNT;
					end
				end
				PH_SKIP: begin
					if (pl == 16'd0) ph = PH_HUNT;
				end
				PH_CHAL: begin
					gs = gs | ({56'd0, rx_byte} << {mc[2:0], 3'b000});
					mc = mc + 4'd1;
					if (mc == 4'd4) begin
						if (gs[31:0] != chal_q) begin
							emit(e0, e1, n, mk_ev(EV_CHAL_MISMATCH, gs, '0, '0, 1'b0));
							ph = (pl == 16'd0) ? PH_HUNT : PH_SKIP;
						end else if (pl == 16'd0) begin
							emit(e0, e1, n, mk_ev(EV_OVERFLOW, '0, '0, '0, 1'b0));
							ph = PH_HUNT;
						end else begin
							ph = PH_CID; mc = '0; gs = '0;
						end
					end else if (pl == 16'd0) begin
						emit(e0, e1, n, mk_ev(EV_OVERFLOW, '0, '0, '0, 1'b0));
						ph = PH_HUNT;
					end
				end
				PH_CID: begin
					gs = gs | ({56'd0, rx_byte} << {mc[2:0], 3'b000});
					mc = mc + 4'd1;
					if (mc == 4'd8) begin
						emit(e0, e1, n, mk_ev(EV_IDENTITY, gs, '0, '0, 1'b0));
						if (pl == 16'd0) begin
							emit(e0, e1, n, mk_ev(EV_OVERFLOW, '0, '0, '0, 1'b0));
							ph = PH_HUNT;
						end else begin
							ph = PH_TSIZE; mc = '0; gs = '0;
						end
					end else if (pl == 16'd0) begin
						emit(e0, e1, n, mk_ev(EV_OVERFLOW, '0, '0, '0, 1'b0));
						ph = PH_HUNT;
					end
				end
				PH_TSIZE: begin
					gs = gs | ({56'd0, rx_byte} << {mc[2:0], 3'b000});
					mc = mc + 4'd1;
					if (mc == 4'd4) begin
						len = gs[31:0];
						if (len > 32'(TICKET_MAX)) begin
							emit(e0, e1, n, mk_ev(EV_TICKET_BIG, {32'd0, len}, '0, '0, 1'b0));
							ph = (pl == 16'd0) ? PH_HUNT : PH_SKIP;
						end else if (len > {16'd0, pl}) begin
							emit(e0, e1, n, mk_ev(EV_OVERFLOW, {32'd0, len}, '0, '0, 1'b0));
							ph = (pl == 16'd0) ? PH_HUNT : PH_SKIP;
						end else if (len == 32'd0) begin
							emit(e0, e1, n, mk_ev(EV_TICKET_BYTE, '0, '0, '0, 1'b1));
							ph = (pl == 16'd0) ? PH_HUNT : PH_SKIP;
						end else begin
							fl = len; gs = {32'd0, len}; ph = PH_TICKET;
						end
					end else if (pl == 16'd0) begin
						emit(e0, e1, n, mk_ev(EV_OVERFLOW, '0, '0, '0, 1'b0));
						ph = PH_HUNT;
					end
				end
				PH_TICKET: begin
					if (fl != 32'd0) fl = fl - 32'd1;
					emit(e0, e1, n, mk_ev(EV_TICKET_BYTE, gs, rx_byte, '0, fl == 32'd0));
					if (fl == 32'd0) ph = (pl == 16'd0) ? PH_HUNT : PH_SKIP;
				end
				PH_PID: begin
					gs = gs | ({56'd0, rx_byte} << {mc[2:0], 3'b000});
					mc = mc + 4'd1;
					if (mc == 4'd8) begin
						emit(e0, e1, n, mk_ev(EV_PLAYER_BEGIN, gs, '0, '0, 1'b0));
						ph = PH_PFLAGS; mc = '0; gs = '0;
					end
				end
				PH_PFLAGS: begin
					mc = mc + 4'd1;
					if (mc == 4'd4) begin
						if (pl == 16'd0) begin
							emit(e0, e1, n, mk_ev(EV_PLAYER_DONE, '0, '0, '0, 1'b0));
							ph = PH_HUNT;
						end else begin
							ph = PH_FTYPE;
						end
					end
				end
				PH_FTYPE: begin
					ct = rx_byte;
					if (pl < 16'd4) begin
						emit(e0, e1, n, mk_ev(EV_PLAYER_ABANDON, '0, '0, '0, 1'b0));
						ph = (pl == 16'd0) ? PH_HUNT : PH_SKIP;
					end else begin
						ph = PH_FLEN; mc = '0; gs = '0;
					end
				end
				PH_FLEN: begin
					gs = gs | ({56'd0, rx_byte} << {mc[2:0], 3'b000});
					mc = mc + 4'd1;
					if (mc == 4'd4) begin
						len = gs[31:0];
						if (len > {16'd0, pl}) begin
							emit(e0, e1, n, mk_ev(EV_PLAYER_DONE, '0, '0, '0, 1'b0));
							ph = (pl == 16'd0) ? PH_HUNT : PH_SKIP;
						end else begin
							fl = len;
							ph = PH_FSKIP;
							priority case (ct)
								FT_NAME: begin
									if (len >= 32'(NAME_BYTES))
										emit(e0, e1, n, mk_ev(EV_NAME_LONG, {32'd0, len}, '0, '0, 1'b0));
									else if (len == 32'd0)
										emit(e0, e1, n, mk_ev(EV_NAME_BYTE, '0, '0, '0, 1'b1));
									else begin
										gs = {32'd0, len}; ph = PH_FDATA;
									end
								end
								FT_AVATAR: begin
									if (len > 32'(AVATAR_MAX))
										emit(e0, e1, n, mk_ev(EV_AVATAR_BIG, {32'd0, len}, '0, '0, 1'b0));
									else if (len == 32'd0)
										emit(e0, e1, n, mk_ev(EV_AVATAR_BYTE, '0, '0, '0, 1'b1));
									else begin
										gs = {32'd0, len}; ph = PH_FDATA;
									end
								end
								FT_RSV3, FT_RSV4, FT_RSV6, FT_RSV8: begin
								end
								FT_RELATION, FT_PERSONA: begin
									if (len != 32'd0) ph = PH_FBYTE;
								end
								FT_GAME: begin
									if (len >= 32'd4) begin
										ph = PH_FGAME; mc = '0; gs = '0;
									end
								end
								default: begin
									emit(e0, e1, n, mk_ev(EV_UNKNOWN_FIELD, {32'd0, len}, '0, ct, 1'b0));
								end
							endcase
							if (fl == 32'd0) begin
								if (pl == 16'd0) begin
									emit(e0, e1, n, mk_ev(EV_PLAYER_DONE, '0, '0, '0, 1'b0));
									ph = PH_HUNT;
								end else begin
									ph = PH_FTYPE;
								end
							end
						end
					end
				end
				PH_FDATA: begin
					if (fl != 32'd0) fl = fl - 32'd1;
					emit(e0, e1, n, mk_ev((ct == FT_NAME) ? EV_NAME_BYTE : EV_AVATAR_BYTE,
						gs, rx_byte, '0, fl == 32'd0));
					if (fl == 32'd0) begin
						if (pl == 16'd0) begin
							emit(e0, e1, n, mk_ev(EV_PLAYER_DONE, '0, '0, '0, 1'b0));
							ph = PH_HUNT;
						end else begin
							ph = PH_FTYPE;
						end
					end
				end
				PH_FBYTE: begin
					if (fl != 32'd0) fl = fl - 32'd1;
					emit(e0, e1, n, mk_ev((ct == FT_RELATION) ? EV_RELATION : EV_PERSONA,
						{56'd0, rx_byte}, '0, '0, 1'b0));
					ph = PH_FSKIP;
					if (fl == 32'd0) begin
						if (pl == 16'd0) begin
							emit(e0, e1, n, mk_ev(EV_PLAYER_DONE, '0, '0, '0, 1'b0));
							ph = PH_HUNT;
						end else begin
							ph = PH_FTYPE;
						end
					end
				end
				PH_FGAME: begin
					if (fl != 32'd0) fl = fl - 32'd1;
					gs = gs | ({56'd0, rx_byte} << {mc[2:0], 3'b000});
					mc = mc + 4'd1;
					if (mc == 4'd4) begin
						emit(e0, e1, n, mk_ev(EV_GAME, gs, '0, '0, 1'b0));
						ph = PH_FSKIP;
					end
					if (fl == 32'd0) begin
						if (pl == 16'd0) begin
							emit(e0, e1, n, mk_ev(EV_PLAYER_DONE, '0, '0, '0, 1'b0));
							ph = PH_HUNT;
						end else begin
							ph = PH_FTYPE;
						end
					end
				end
				default: begin
					if (fl != 32'd0) fl = fl - 32'd1;
					if (fl == 32'd0) begin
						if (pl == 16'd0) begin
							emit(e0, e1, n, mk_ev(EV_PLAYER_DONE, '0, '0, '0, 1'b0));
							ph = PH_HUNT;
						end else begin
							ph = PH_FTYPE;
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		push.n  = take ? n : 2'd0;
		push.e0 = e0;
		push.e1 = e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			mc_q    <= '0;
			pl_q    <= '0;
			fl_q    <= '0;
			ct_q    <= '0;
			gs_q    <= '0;
			rk_q    <= '0;
			chal_q  <= '0;
		end else begin
			if (cfg_wr_en) chal_q <= cfg_wr_data;
			if (take) begin
				phase_q <= ph;
				mc_q    <= mc;
				pl_q    <= pl;
				fl_q    <= fl;
				ct_q    <= ct;
				gs_q    <= gs;
				rk_q    <= rk;
			end
		end
	end

endmodule

// File: rtl/ftrp_evq.sv
// Small event queue: takes up to two events per cycle, releases one beat per cycle while out_ready is high.
// Depends on ftrp_pkg.
module ftrp_evq (
	input  logic            clk,
	input  logic            arst_n,
	input  ftrp_pkg::push_t push,
	output logic            room2,
	output logic            out_valid,
	input  logic            out_ready,
	output ftrp_pkg::ev_t   head
);
	import ftrp_pkg::*;

	localparam int unsigned AW = $clog2(EVQ_DEPTH);

	ev_t           mem_q [EVQ_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign room2     = (cnt_q <= (AW+1)'(EVQ_DEPTH - 2));
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_q] <= push.e0;
		if (push.n == 2'd2) mem_q[wr_q + AW'(1)] <= push.e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push.n);
			if (pop) rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push.n) - (AW+1)'(pop);
		end
	end

endmodule

// File: sim/framed_tlv_response_parser_core_test.sv
// Self-checking bench for framed_tlv_response_parser_core: random SBRK frames in,
// events checked against an in-bench parser model.
// Depends on ftrp_pkg, ftrp_in_if, ftrp_out_if and the parser RTL.
module framed_tlv_response_parser_core_test;
	import ftrp_pkg::*;

	typedef enum int {
		P_HUNT, P_LEN0, P_LEN1, P_HDR, P_SKIP, P_CHAL, P_CID, P_TSIZE, P_TICKET,
		P_PID, P_PFLAGS, P_FTYPE, P_FLEN, P_FDATA, P_FBYTE, P_FGAME, P_FSKIP
	} parse_ph_t;

	typedef struct {
		logic [7:0] b;
		logic       rs;
	} rx_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	ftrp_in_if  in_ch ();
	ftrp_out_if out_ch ();

	framed_tlv_response_parser_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch)
	);

	rx_beat_t  rx_pending[$];
	ev_t       events_due[$];
	int        n_errors;
	bit        steady;
	int        hold_req;
	int        hold_seen;
	int        hold_left;
	bit        in_took;

	// parser model state
	parse_ph_t   ph;
	logic [3:0]  mcnt;
	logic [15:0] pay_left;
	logic [31:0] fld_left;
	logic [7:0]  ctype;
	logic [63:0] acc;
	logic [1:0]  rkind;
	logic [31:0] challenge;
	int          n_ev;

	string magic_s = "SBRK";

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		n_errors++;
	endtask

	task automatic emit_ev(input ev_code_t c, input logic [63:0] v, input logic [7:0] d,
			input logic [7:0] k, input logic l);
		ev_t e;
		if (n_ev < 2) begin
			e.event_res = c;
			e.value = v;
			e.data_byte = d;
			e.field_kind = k;
			e.last = l;
			events_due.push_back(e);
			n_ev++;
		end
	endtask

	function automatic void clear_parse();
		ph = P_HUNT;
		mcnt = 0;
		pay_left = 0;
		fld_left = 0;
		ctype = 0;
		acc = 0;
		rkind = 0;
	endfunction

	function automatic void to_end_or_skip();
		ph = (pay_left == 0) ? P_HUNT : P_SKIP;
	endfunction

	function automatic void begin_gather(input parse_ph_t nxt);
		ph = nxt;
		mcnt = 0;
		acc = 0;
	endfunction

	function automatic void take_le(input logic [7:0] b);
		acc |= 64'(b) << ((8 * int'(mcnt)) & 63);
		mcnt = mcnt + 4'd1;
	endfunction

	task automatic close_field();
		if (pay_left == 0) begin
			emit_ev(EV_PLAYER_DONE, 0, 0, 0, 0);
			ph = P_HUNT;
		end else begin
			ph = P_FTYPE;
		end
	endtask

	task automatic route_field(input logic [31:0] len);
		fld_left = len;
		ph = P_FSKIP;
		case (ctype)
			FT_NAME: begin
				if (len >= NAME_BYTES) emit_ev(EV_NAME_LONG, len, 0, 0, 0);
				else if (len == 0) emit_ev(EV_NAME_BYTE, 0, 0, 0, 1);
				else begin acc = len; ph = P_FDATA; end
			end
			FT_AVATAR: begin
				if (len > AVATAR_MAX) emit_ev(EV_AVATAR_BIG, len, 0, 0, 0);
				else if (len == 0) emit_ev(EV_AVATAR_BYTE, 0, 0, 0, 1);
				else begin acc = len; ph = P_FDATA; end
			end
			FT_RSV3, FT_RSV4, FT_RSV6, FT_RSV8: ;
			FT_RELATION, FT_PERSONA: if (len != 0) ph = P_FBYTE;
			FT_GAME: if (len >= 4) begin_gather(P_FGAME);
			default: emit_ev(EV_UNKNOWN_FIELD, len, 0, ctype, 0);
		endcase
		if (fld_left == 0) close_field();
	endtask

	task automatic hunt(input logic [7:0] b);
		int idx;
		idx = mcnt & 3;
		if (b == magic_s[idx]) begin
			mcnt = 4'(idx + 1);
			if (mcnt == 4) begin_gather(P_LEN0);
		end else begin
			emit_ev(EV_BAD_MAGIC, 0, 0, 0, 0);
			mcnt = (b == magic_s[0]) ? 4'd1 : 4'd0;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic rs);
		logic [31:0] len;
		int idx;
		n_ev = 0;
		if (rs) clear_parse();
		if (ph >= P_HDR) begin
			if (pay_left == 0) begin
				clear_parse();
				hunt(b);
				return;
			end
			pay_left--;
		end
		case (ph)
			P_HUNT: hunt(b);
			P_LEN0: begin take_le(b); ph = P_LEN1; end
			P_LEN1: begin
				len = {16'd0, b, acc[7:0]};
				if (len > MAX_PAYLOAD) begin
					emit_ev(EV_OVERFLOW, len, 0, 0, 0);
					clear_parse();
				end else if (len == 0) begin
					emit_ev(EV_UNKNOWN_REPLY, 0, 0, 0, 0);
					clear_parse();
				end else begin
					pay_left = len[15:0];
					ph = P_HDR;
					mcnt = 0;
					rkind = 3;
				end
			end
			P_HDR: begin
				idx = mcnt;
				if (idx >= HDR_LEN) idx = HDR_LEN - 1;
				if (b != hdr_byte(1'b0, 4'(idx))) rkind[0] = 0;
				if (b != hdr_byte(1'b1, 4'(idx))) rkind[1] = 0;
				mcnt = 4'(idx + 1);
				if (rkind == 0) begin
					emit_ev(EV_UNKNOWN_REPLY, 0, 0, 0, 0);
					to_end_or_skip();
				end else if (mcnt == HDR_LEN) begin
					if (rkind[0]) begin
						if (pay_left == 0) begin
							emit_ev(EV_OVERFLOW, 0, 0, 0, 0);
							ph = P_HUNT;
						end else begin_gather(P_CHAL);
					end else if (pay_left < 12) begin
						emit_ev(EV_PLAYER_ABANDON, 0, 0, 0, 0);
						to_end_or_skip();
					end else begin_gather(P_PID);
				end else if (pay_left == 0) begin
					emit_ev(EV_UNKNOWN_REPLY, 0, 0, 0, 0);
					ph = P_HUNT;
				end
			end
			P_SKIP: if (pay_left == 0) ph = P_HUNT;
			P_CHAL: begin
				take_le(b);
				if (mcnt == 4) begin
					if (acc[31:0] != challenge) begin
						emit_ev(EV_CHAL_MISMATCH, acc, 0, 0, 0);
						to_end_or_skip();
					end else if (pay_left == 0) begin
						emit_ev(EV_OVERFLOW, 0, 0, 0, 0);
						ph = P_HUNT;
					end else begin_gather(P_CID);
				end else if (pay_left == 0) begin
					emit_ev(EV_OVERFLOW, 0, 0, 0, 0);
					ph = P_HUNT;
				end
			end
			P_CID: begin
				take_le(b);
				if (mcnt == 8) begin
					emit_ev(EV_IDENTITY, acc, 0, 0, 0);
					if (pay_left == 0) begin
						emit_ev(EV_OVERFLOW, 0, 0, 0, 0);
						ph = P_HUNT;
					end else begin_gather(P_TSIZE);
				end else if (pay_left == 0) begin
					emit_ev(EV_OVERFLOW, 0, 0, 0, 0);
					ph = P_HUNT;
				end
			end
			P_TSIZE: begin
				take_le(b);
				if (mcnt == 4) begin
					len = acc[31:0];
					if (len > TICKET_MAX) begin
						emit_ev(EV_TICKET_BIG, len, 0, 0, 0);
						to_end_or_skip();
					end else if (len > pay_left) begin
						emit_ev(EV_OVERFLOW, len, 0, 0, 0);
						to_end_or_skip();
					end else if (len == 0) begin
						emit_ev(EV_TICKET_BYTE, 0, 0, 0, 1);
						to_end_or_skip();
					end else begin
						fld_left = len;
						acc = len;
						ph = P_TICKET;
					end
				end else if (pay_left == 0) begin
					emit_ev(EV_OVERFLOW, 0, 0, 0, 0);
					ph = P_HUNT;
				end
			end
			P_TICKET: begin
				if (fld_left != 0) fld_left--;
				emit_ev(EV_TICKET_BYTE, acc, b, 0, fld_left == 0);
				if (fld_left == 0) to_end_or_skip();
			end
			P_PID: begin
				take_le(b);
				if (mcnt == 8) begin
					emit_ev(EV_PLAYER_BEGIN, acc, 0, 0, 0);
					begin_gather(P_PFLAGS);
				end
			end
			P_PFLAGS: begin
				mcnt = mcnt + 4'd1;
				if (mcnt == 4) close_field();
			end
			P_FTYPE: begin
				ctype = b;
				if (pay_left < 4) begin
					emit_ev(EV_PLAYER_ABANDON, 0, 0, 0, 0);
					to_end_or_skip();
				end else begin_gather(P_FLEN);
			end
			P_FLEN: begin
				take_le(b);
				if (mcnt == 4) begin
					len = acc[31:0];
					if (len > pay_left) begin
						emit_ev(EV_PLAYER_DONE, 0, 0, 0, 0);
						to_end_or_skip();
					end else route_field(len);
				end
			end
			P_FDATA: begin
				if (fld_left != 0) fld_left--;
				emit_ev(ctype == FT_NAME ? EV_NAME_BYTE : EV_AVATAR_BYTE, acc, b, 0,
					fld_left == 0);
				if (fld_left == 0) close_field();
			end
			P_FBYTE: begin
				if (fld_left != 0) fld_left--;
				emit_ev(ctype == FT_RELATION ? EV_RELATION : EV_PERSONA, b, 0, 0, 0);
				ph = P_FSKIP;
				if (fld_left == 0) close_field();
			end
			P_FGAME: begin
				if (fld_left != 0) fld_left--;
				take_le(b);
				if (mcnt == 4) begin
					emit_ev(EV_GAME, acc, 0, 0, 0);
					ph = P_FSKIP;
				end
				if (fld_left == 0) close_field();
			end
			default: begin
				if (fld_left != 0) fld_left--;
				if (fld_left == 0) close_field();
			end
		endcase
	endtask

	// ---------------- stimulus builders ----------------
	task automatic push_byte(input logic [7:0] b, input logic rs = 0);
		rx_beat_t x;
		x.b = b;
		x.rs = rs;
		rx_pending.push_back(x);
	endtask

	task automatic push_le(inout logic [7:0] q[$], input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++) q.push_back(v[8*i +: 8]);
	endtask

	// wraps a payload in magic and length; sometimes lies about the length, corrupts a byte or sets restart
	task automatic send_frame(input logic [7:0] pay[$]);
		int len;
		len = pay.size();
		case ($urandom_range(19))
			0: len = $urandom_range(len);
			1: len = len + $urandom_range(1, 6);
			2: len = $urandom_range(MAX_PAYLOAD + 1, 65535);
			default: ;
		endcase
		for (int i = 0; i < 4; i++) push_byte(magic_s[i], i == 0 && $urandom_range(29) == 0);
		push_byte(len[7:0]);
		push_byte(len[15:8]);
		foreach (pay[i]) begin
			if ($urandom_range(299) == 0) push_byte($urandom, 1);
			else if ($urandom_range(199) == 0) push_byte($urandom);
			else push_byte(pay[i]);
		end
	endtask

	task automatic add_header(inout logic [7:0] q[$], input bit player);
		for (int i = 0; i < HDR_LEN; i++) q.push_back(hdr_byte(player, 4'(i)));
		if ($urandom_range(14) == 0) q[$urandom_range(HDR_LEN - 1)] = $urandom;
	endtask

	task automatic connect_frame();
		logic [7:0] q[$];
		logic [31:0] tsz;
		add_header(q, 0);
		push_le(q, ($urandom_range(4) == 0) ? 64'($urandom) : 64'(challenge), 4);
		push_le(q, {$urandom, $urandom}, 8);
		case ($urandom_range(9))
			0: tsz = 0;
			1: tsz = $urandom_range(TICKET_MAX + 1, 70000);
			2: tsz = $urandom;
			3: tsz = TICKET_MAX;
			default: tsz = $urandom_range(1, 12);
		endcase
		push_le(q, tsz, 4);
		if (tsz <= 12)
			for (int i = 0; i < tsz; i++) q.push_back($urandom);
		for (int i = $urandom_range(3) - 2; i > 0; i--) q.push_back($urandom);
		send_frame(q);
	endtask

	task automatic player_frame();
		logic [7:0] q[$];
		logic [7:0] ft;
		logic [31:0] fl;
		int nf;
		add_header(q, 1);
		push_le(q, {$urandom, $urandom}, 8);
		push_le(q, $urandom, 4);
		nf = $urandom_range(5);
		for (int f = 0; f < nf; f++) begin
			ft = ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(1, 9));
			case ($urandom_range(15))
				0: fl = (ft == FT_NAME) ? NAME_BYTES : NAME_BYTES - 1;
				1: fl = $urandom;
				default: fl = $urandom_range(6);
			endcase
			q.push_back(ft);
			push_le(q, fl, 4);
			if (fl <= NAME_BYTES) for (int i = 0; i < fl; i++) q.push_back($urandom);
		end
		if ($urandom_range(5) == 0) for (int i = $urandom_range(1, 4); i > 0; i--)
			q.push_back($urandom);
		if ($urandom_range(9) == 0) q = q[0:$urandom_range(q.size() - 1)];
		send_frame(q);
	endtask

	task automatic fill_random(input int n);
		int goal;
		goal = rx_pending.size() + n;
		while (rx_pending.size() < goal) begin
			case ($urandom_range(9))
				0: for (int i = $urandom_range(1, 4); i > 0; i--) push_byte($urandom, $urandom);
				1, 2, 3, 4: connect_frame();
				default: player_frame();
			endcase
		end
	endtask

	task automatic wait_idle();
		while (rx_pending.size() != 0 || in_ch.valid || events_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_challenge(input logic [31:0] v);
		@(negedge clk);
		cfg_wr_en = 1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 0;
		challenge = v;
	endtask

	// ---------------- clock, reset, timeout ----------------
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------- input driver ----------------
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 0;
		end else if (!in_ch.valid || in_took) begin
			if (rx_pending.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
				in_ch.valid <= 1;
				in_ch.rx_byte <= rx_pending[0].b;
				in_ch.restart <= rx_pending[0].rs;
				void'(rx_pending.pop_front());
			end else begin
				in_ch.valid <= 0;
			end
		end
	end

	// ---------------- output ready, with a long hold when asked ----------------
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 0;
		end else begin
			out_ch.ready <= steady || $urandom_range(99) >= 20;
		end
	end

	// ---------------- predict on input beats, check output beats ----------------
	always @(posedge clk) begin
		ev_t w;
		in_took = arst_n && in_ch.valid && in_ch.ready;
		if (in_took) parse_byte(in_ch.rx_byte, in_ch.restart);
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (events_due.size() == 0) begin
				report($sformatf("unexpected event %0d", out_ch.event_res));
			end else begin
				w = events_due.pop_front();
				if (out_ch.event_res !== w.event_res)
					report($sformatf("event_res %0d, want %0d", out_ch.event_res, w.event_res));
				if (out_ch.value !== w.value)
					report($sformatf("value %h, want %h (event %0d)", out_ch.value, w.value,
						w.event_res));
				if (out_ch.data_byte !== w.data_byte)
					report($sformatf("data_byte %h, want %h", out_ch.data_byte, w.data_byte));
				if (out_ch.field_kind !== w.field_kind)
					report($sformatf("field_kind %h, want %h", out_ch.field_kind, w.field_kind));
				if (out_ch.last !== w.last)
					report($sformatf("last %b, want %b", out_ch.last, w.last));
			end
		end
	end

	// ---------------- main sequence ----------------
	initial begin
		logic [31:0] chal_set[5];
		n_errors = 0;
		steady = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		in_took = 0;
		challenge = 0;
		clear_parse();
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		in_ch.valid = 0;
		in_ch.rx_byte = 0;
		in_ch.restart = 0;
		out_ch.ready = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: bad magic, oversize, empty, restart mid-frame
		push_byte("S"); push_byte("X"); push_byte("S"); push_byte("B"); push_byte("S");
		push_byte("B"); push_byte("R"); push_byte("K"); push_byte(8'h01); push_byte(8'h10);
		push_byte("S"); push_byte("B"); push_byte("R"); push_byte("K"); push_byte(0);
		push_byte(0);
		push_byte("S"); push_byte("B"); push_byte("R"); push_byte("K"); push_byte(8'hFF);
		push_byte(8'hFF, 1); push_byte(8'hFF);
		wait_idle();

		chal_set[0] = 32'h0;
		chal_set[1] = 32'h7FFF_FFFF;
		chal_set[2] = 32'h8000_0000;
		chal_set[3] = 32'hFFFF_FFFF;
		chal_set[4] = $urandom;
		for (int p = 0; p < 5; p++) begin
			write_challenge(chal_set[p]);
			steady = (p == 2);
			if (p == 3) hold_req++;
			fill_random(165);
			wait_idle();
		end

		if (events_due.size() != 0)
			report($sformatf("%0d events never arrived", events_due.size()));
		if (n_errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
